@@ src/assert_macros.svh @@
// Assertion macros shared by the bitmap search RTL.
// Expects a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ src/bfrs_pkg.sv @@
// Package for the bitmap free-run search block: widths, codes, shared types.
// No dependencies.
`default_nettype none

package bfrs_pkg;

   localparam int WORD_BITS            = 32;
   localparam int BIT_W                = 5;
   localparam int INDEX_W              = 3;
   localparam int BYTES_W              = 20;
   localparam int NEED_W               = 21;
   localparam int SHIFT_W              = 4;
   localparam int BITMAP_WORDS_DEFAULT = 8;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN
   } state_type;

   typedef enum logic {
      CMD_WRITE  = 1'b0,
      CMD_SEARCH = 1'b1
   } cmd_type;

   typedef struct packed {
      logic             hit;
      logic [BIT_W-1:0] bit_pos;
   } scan_hit_type;

endpackage

`default_nettype wire

@@ src/bitmap_free_run_search.sv @@
// Bitmap free-run search, top level. Uses bfrs_pkg, bfrs_map_ram, bfrs_word_scan.
// Write beat: busy stays low. Search beat: busy until the response strobe, scanning one bitmap
// word per cycle through the single map read port and stopping at the first hit; rsp_valid
// strobes for one cycle when the answer is ready, and a zero size skips the scan.
// Synchronous reset: idle, region_size_log2 = 4, map undefined.
`default_nettype none

module bitmap_free_run_search #(
   parameter int BITMAP_WORDS = bfrs_pkg::BITMAP_WORDS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_cmd,
   input  wire logic [bfrs_pkg::INDEX_W-1:0]      req_word_index,
   input  wire logic [bfrs_pkg::WORD_BITS-1:0]    req_word_value,
   input  wire logic [bfrs_pkg::BYTES_W-1:0]      req_request_bytes,
   output logic                                   rsp_valid,
   output logic                                   rsp_found,
   output logic      [bfrs_pkg::BYTES_W-1:0]      rsp_byte_offset,
   input  wire logic                              csr_write_enable,
   input  wire logic [bfrs_pkg::SHIFT_W-1:0]      csr_write_data
);

   `include "assert_macros.svh"

   localparam int AW    = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
   localparam int RUN_W = $clog2(BITMAP_WORDS * bfrs_pkg::WORD_BITS + 1);
   localparam int IDX_W = AW + bfrs_pkg::BIT_W;
   localparam int OFF_W = IDX_W + 16;

   bfrs_pkg::state_type state_ff, state_in;

   logic [bfrs_pkg::SHIFT_W-1:0] shift_ff;
   logic [bfrs_pkg::NEED_W-1:0]  need_ff, need_in;
   logic [RUN_W-1:0]             carry_ff, carry_in;
   logic [AW-1:0]                scan_w_ff, scan_w_in;
   logic                         hit_ff, hit_in;
   logic [IDX_W-1:0]             hit_region_ff, hit_region_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [bfrs_pkg::BYTES_W-1:0] rsp_offset_ff, rsp_offset_in;

   logic                           accept;
   logic                           accept_search;
   logic                           last_word;
   logic                           wr_en;
   logic [AW-1:0]                  rd_addr;
   logic [bfrs_pkg::WORD_BITS-1:0] rd_word;
   bfrs_pkg::scan_hit_type         scan_hit;
   logic [RUN_W-1:0]               scan_carry;
   logic [IDX_W:0]                 start_region;
   logic [OFF_W-1:0]               off_wide;

   assign accept        = start && !busy;
   assign accept_search = accept && (req_cmd == bfrs_pkg::CMD_SEARCH);
   assign last_word     = (scan_w_ff == AW'(BITMAP_WORDS - 1));

   bfrs_map_ram #(
      .WORDS (BITMAP_WORDS),
      .AW    (AW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_word_index)),
      .wr_data (req_word_value),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   bfrs_word_scan #(
      .RUN_W (RUN_W)
   ) u_word_scan (
      .word      (rd_word),
      .carry_in  (carry_ff),
      .need      (need_ff),
      .hit_out   (scan_hit),
      .carry_out (scan_carry)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfrs_pkg::ST_IDLE: begin
            if (accept_search) begin
               state_in = (req_request_bytes == '0) ? bfrs_pkg::ST_FIN : bfrs_pkg::ST_SCAN;
            end
         end
         bfrs_pkg::ST_SCAN: begin
            if (scan_hit.hit || last_word) begin
               state_in = bfrs_pkg::ST_FIN;
            end
         end
         bfrs_pkg::ST_FIN: begin
            state_in = bfrs_pkg::ST_IDLE;
         end
         default: begin
            state_in = bfrs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy    = 1'b1;
      wr_en   = 1'b0;
      rd_addr = '0;
      case (state_ff)
         bfrs_pkg::ST_IDLE: begin
            busy  = 1'b0;
            wr_en = start && (req_cmd == bfrs_pkg::CMD_WRITE)
                    && (32'(req_word_index) < BITMAP_WORDS);
         end
         bfrs_pkg::ST_SCAN: begin
            rd_addr = last_word ? '0 : AW'(scan_w_ff + AW'(1));
         end
         bfrs_pkg::ST_FIN: begin
            rd_addr = '0;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_comb begin
      need_in       = need_ff;
      carry_in      = carry_ff;
      scan_w_in     = scan_w_ff;
      hit_in        = hit_ff;
      hit_region_in = hit_region_ff;
      rsp_valid_in  = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_offset_in = rsp_offset_ff;

      start_region = {1'b0, hit_region_ff} + (IDX_W+1)'(1) - need_ff[IDX_W:0];
      off_wide     = OFF_W'(start_region[IDX_W-1:0]) << shift_ff;

      case (state_ff)
         bfrs_pkg::ST_IDLE: begin
            need_in   = (bfrs_pkg::NEED_W'(req_request_bytes)
                        + ((bfrs_pkg::NEED_W'(1) << shift_ff) - bfrs_pkg::NEED_W'(1)))
                        >> shift_ff;
            carry_in  = '0;
            scan_w_in = '0;
            hit_in    = 1'b0;
         end
         bfrs_pkg::ST_SCAN: begin
            carry_in      = scan_carry;
            scan_w_in     = AW'(scan_w_ff + AW'(1));
            hit_in        = scan_hit.hit;
            hit_region_in = {scan_w_ff, scan_hit.bit_pos};
         end
         bfrs_pkg::ST_FIN: begin
            rsp_valid_in = 1'b1;
            if (hit_ff && (off_wide[OFF_W-1:bfrs_pkg::BYTES_W] == '0)) begin
               rsp_found_in  = 1'b1;
               rsp_offset_in = off_wide[bfrs_pkg::BYTES_W-1:0];
            end else begin
               rsp_found_in  = 1'b0;
               rsp_offset_in = '0;
            end
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfrs_pkg::ST_IDLE;
         shift_ff     <= bfrs_pkg::SHIFT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            shift_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      need_ff       <= need_in;
      carry_ff      <= carry_in;
      scan_w_ff     <= scan_w_in;
      hit_ff        <= hit_in;
      hit_region_ff <= hit_region_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_byte_offset = rsp_offset_ff;

   `ASSERT_NEXT(a_search_goes_busy, accept_search, busy)
   `ASSERT_NEXT(a_write_stays_idle, accept && !accept_search, !busy && !rsp_valid)
   `ASSERT_IMPL(a_miss_zero_offset, rsp_valid && !rsp_found, rsp_byte_offset == '0)
   `ASSERT_IMPL(a_strobe_only_idle, rsp_valid, state_ff == bfrs_pkg::ST_IDLE)

endmodule

`default_nettype wire

@@ src/bfrs_map_ram.sv @@
// Free-region bitmap storage: one write port, one registered read port.
// Depends on bfrs_pkg for the word width.
`default_nettype none

module bfrs_map_ram #(
   parameter int WORDS = bfrs_pkg::BITMAP_WORDS_DEFAULT,
   parameter int AW    = 3
) (
   input  wire logic                           clock,
   input  wire logic                           wr_en,
   input  wire logic [AW-1:0]                  wr_addr,
   input  wire logic [bfrs_pkg::WORD_BITS-1:0] wr_data,
   input  wire logic [AW-1:0]                  rd_addr,
   output logic      [bfrs_pkg::WORD_BITS-1:0] rd_data
);

   logic [bfrs_pkg::WORD_BITS-1:0] mem [WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ src/bfrs_word_scan.sv @@
// One-word run scan: finds the first bit where the free run reaches need,
// carrying the run length across words. Depends on bfrs_pkg.
`default_nettype none

module bfrs_word_scan #(
   parameter int RUN_W = 9
) (
   input  wire logic [bfrs_pkg::WORD_BITS-1:0] word,
   input  wire logic [RUN_W-1:0]               carry_in,
   input  wire logic [bfrs_pkg::NEED_W-1:0]    need,
   output bfrs_pkg::scan_hit_type              hit_out,
   output logic      [RUN_W-1:0]               carry_out
);

   localparam int LEVELS = bfrs_pkg::BIT_W;

   logic                         zero_seen [LEVELS+1][bfrs_pkg::WORD_BITS];
   logic [bfrs_pkg::BIT_W-1:0]   zero_pos  [LEVELS+1][bfrs_pkg::WORD_BITS];
   logic [bfrs_pkg::NEED_W-1:0]  run_len   [bfrs_pkg::WORD_BITS];
   logic [bfrs_pkg::WORD_BITS-1:0] hit_vec;

   // last allocated region at or below each bit, by doubling steps
   always_comb begin
      for (int b = 0; b < bfrs_pkg::WORD_BITS; b++) begin
         zero_seen[0][b] = ~word[b];
         zero_pos[0][b]  = bfrs_pkg::BIT_W'(b);
      end
      for (int s = 0; s < LEVELS; s++) begin
         for (int b = 0; b < bfrs_pkg::WORD_BITS; b++) begin
            if (!zero_seen[s][b] && (b >= (1 << s))) begin
               zero_seen[s+1][b] = zero_seen[s][b - (1 << s)];
               zero_pos[s+1][b]  = zero_pos[s][b - (1 << s)];
            end else begin
               zero_seen[s+1][b] = zero_seen[s][b];
               zero_pos[s+1][b]  = zero_pos[s][b];
            end
         end
      end
   end

   always_comb begin
      for (int b = 0; b < bfrs_pkg::WORD_BITS; b++) begin
         if (zero_seen[LEVELS][b]) begin
            run_len[b] = bfrs_pkg::NEED_W'(bfrs_pkg::BIT_W'(b) - zero_pos[LEVELS][b]);
         end else begin
            run_len[b] = bfrs_pkg::NEED_W'(carry_in) + bfrs_pkg::NEED_W'(b)
                       + bfrs_pkg::NEED_W'(1);
         end
         hit_vec[b] = (run_len[b] >= need);
      end
   end

   always_comb begin
      hit_out.hit     = |hit_vec;
      hit_out.bit_pos = '0;
      for (int b = bfrs_pkg::WORD_BITS - 1; b >= 0; b--) begin
         if (hit_vec[b]) begin
            hit_out.bit_pos = bfrs_pkg::BIT_W'(b);
         end
      end
   end

   always_comb begin
      if (zero_seen[LEVELS][bfrs_pkg::WORD_BITS-1]) begin
         carry_out = RUN_W'(bfrs_pkg::BIT_W'(bfrs_pkg::WORD_BITS - 1)
                   - zero_pos[LEVELS][bfrs_pkg::WORD_BITS-1]);
      end else begin
         carry_out = carry_in + RUN_W'(bfrs_pkg::WORD_BITS);
      end
   end

endmodule

`default_nettype wire

@@ dv/free_run_checker.sv @@
// Checker for bitmap_free_run_search: tracks map writes and the region size,
// predicts each search answer and compares it with the response strobe.
// Depends on bfrs_pkg.
`timescale 1ns / 100ps

module free_run_checker
   import bfrs_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic                 req_cmd,
   input  logic [INDEX_W-1:0]   req_word_index,
   input  logic [WORD_BITS-1:0] req_word_value,
   input  logic [BYTES_W-1:0]   req_request_bytes,
   input  logic                 rsp_valid,
   input  logic                 rsp_found,
   input  logic [BYTES_W-1:0]   rsp_byte_offset,
   input  logic                 csr_write_enable,
   input  logic [SHIFT_W-1:0]   csr_write_data,
   output int unsigned          fail_count,
   output int unsigned          pending
);

   localparam int MAP_WORDS = BITMAP_WORDS_DEFAULT;

   typedef struct packed {
      logic               found;
      logic [BYTES_W-1:0] byte_offset;
   } free_run_type;

   logic [WORD_BITS-1:0] free_words [MAP_WORDS];
   logic [SHIFT_W-1:0]   region_shift = SHIFT_RESET;
   free_run_type         expected_runs [$];
   int unsigned          errors = 0;

   initial begin
      for (int w = 0; w < MAP_WORDS; w++) free_words[w] = '0;
   end

   assign fail_count = errors;

   function automatic free_run_type first_fit_run(input logic [BYTES_W-1:0] bytes);
      logic [63:0]  need;
      logic [63:0]  run;
      logic [63:0]  first_region;
      logic [63:0]  offset;
      free_run_type res;
      res = '0;
      need = ({44'd0, bytes} + (64'd1 << region_shift) - 64'd1) >> region_shift;
      if (need == 0) return res;
      run = 0;
      for (int i = 0; i < MAP_WORDS * WORD_BITS; i++) begin
         if (free_words[i / WORD_BITS][i % WORD_BITS]) run++;
         else run = 0;
         if (run == need) begin
            first_region = 64'(i) + 64'd1 - run;
            offset = first_region << region_shift;
            if (offset <= 64'hFFFFF) begin
               res.found = 1'b1;
               res.byte_offset = offset[BYTES_W-1:0];
            end
            return res;
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin : watch
      free_run_type want;
      if (reset) begin
         region_shift = SHIFT_RESET;
         expected_runs.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_runs.size() == 0) begin
               $display("%0t unexpected beat: expected none, actual found %0b offset %0h",
                        $time, rsp_found, rsp_byte_offset);
               errors++;
            end else begin
               want = expected_runs.pop_front();
               if (rsp_found !== want.found) begin
                  $display("%0t found: expected %0b actual %0b",
                           $time, want.found, rsp_found);
                  errors++;
               end
               if (rsp_byte_offset !== want.byte_offset) begin
                  $display("%0t byte_offset: expected %0h actual %0h",
                           $time, want.byte_offset, rsp_byte_offset);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            if (req_cmd == CMD_SEARCH)
               expected_runs.push_back(first_fit_run(req_request_bytes));
            else if (req_word_index < MAP_WORDS)
               free_words[req_word_index] = req_word_value;
         end
         if (csr_write_enable) region_shift = csr_write_data;
      end
      pending <= expected_runs.size();
   end

endmodule

@@ dv/tb_bitmap_free_run_search.sv @@
// Testbench top for bitmap_free_run_search: clock, reset, map and search stimulus,
// region size changes between phases. Depends on bfrs_pkg and free_run_checker.
`timescale 1ns / 100ps

module tb_bitmap_free_run_search;
   import bfrs_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic                 req_cmd = 1'b0;
   logic [INDEX_W-1:0]   req_word_index = '0;
   logic [WORD_BITS-1:0] req_word_value = '0;
   logic [BYTES_W-1:0]   req_request_bytes = '0;
   logic                 rsp_valid;
   logic                 rsp_found;
   logic [BYTES_W-1:0]   rsp_byte_offset;
   logic                 csr_write_enable = 1'b0;
   logic [SHIFT_W-1:0]   csr_write_data = '0;

   int unsigned          fail_total;
   int unsigned          results_pending;
   int unsigned          cycle_count = 0;
   logic [SHIFT_W-1:0]   region_shift = SHIFT_RESET;

   bitmap_free_run_search dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_word_index    (req_word_index),
      .req_word_value    (req_word_value),
      .req_request_bytes (req_request_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_byte_offset   (rsp_byte_offset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   free_run_checker run_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_cmd           (req_cmd),
      .req_word_index    (req_word_index),
      .req_word_value    (req_word_value),
      .req_request_bytes (req_request_bytes),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_byte_offset   (rsp_byte_offset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_total),
      .pending           (results_pending)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_beat(input cmd_type cmd, input logic [INDEX_W-1:0] idx,
                            input logic [WORD_BITS-1:0] word,
                            input logic [BYTES_W-1:0] bytes);
      start             <= 1'b1;
      req_cmd           <= cmd;
      req_word_index    <= idx;
      req_word_value    <= word;
      req_request_bytes <= bytes;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_gap(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_region_size(input logic [SHIFT_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      region_shift = value;
   endtask

   function automatic logic [WORD_BITS-1:0] pick_map_word();
      int unsigned kind;
      int unsigned lo;
      int unsigned len;
      logic [63:0] mask;
      kind = $urandom_range(0, 5);
      case (kind)
         0: return '1;
         1: return '0;
         2: return $urandom;
         3: return $urandom | $urandom;
         4: begin
            lo = $urandom_range(0, 31);
            len = $urandom_range(1, 32);
            mask = ((64'd1 << len) - 64'd1) << lo;
            return mask[WORD_BITS-1:0];
         end
         default: return $urandom & $urandom;
      endcase
   endfunction

   function automatic logic [BYTES_W-1:0] pick_request_bytes();
      int unsigned pick;
      logic [63:0] regions;
      logic [63:0] want;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return BYTES_W'($urandom);
      if (pick == 2) return '1;
      regions = 64'($urandom_range(1, (pick < 6) ? 8 : 96));
      want = (regions << region_shift)
             - 64'($urandom_range(0, (1 << region_shift) - 1));
      if (want > 64'hFFFFF) return BYTES_W'($urandom);
      return want[BYTES_W-1:0];
   endfunction

   initial begin
      int unsigned phase_shift [8];
      phase_shift = '{0, 12, 15, 4, 13, 7, 2, 9};
      phase_shift[7] = $urandom_range(0, 15);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset region size of 16 bytes
      send_beat(CMD_WRITE, 3'd0, 32'h0000_0001, 20'd0);
      send_beat(CMD_WRITE, 3'd1, 32'hFFFF_0000, 20'd0);
      send_beat(CMD_WRITE, 3'd2, 32'hFFFF_FFFF, 20'd0);
      send_beat(CMD_WRITE, 3'd3, 32'h0000_0000, 20'd0);
      send_beat(CMD_WRITE, 3'd4, 32'h0000_0000, 20'd0);
      send_beat(CMD_WRITE, 3'd5, 32'h0000_0000, 20'd0);
      send_beat(CMD_WRITE, 3'd6, 32'h0000_0000, 20'd0);
      send_beat(CMD_WRITE, 3'd7, 32'h8000_0000, 20'd0);
      send_beat(CMD_SEARCH, 3'd0, 32'd0, 20'd0);
      send_beat(CMD_SEARCH, 3'd0, 32'd0, 20'd1);
      send_beat(CMD_SEARCH, 3'd0, 32'd0, 20'd16);
      send_beat(CMD_SEARCH, 3'd0, 32'd0, 20'd17);
      send_beat(CMD_SEARCH, 3'd0, 32'd0, 20'd768);
      send_beat(CMD_SEARCH, 3'd7, '1, 20'hFFFFF);
      wait_all_results();

      // offsets past 20 bits with 8 KiB regions
      write_region_size(4'd13);
      send_beat(CMD_WRITE, 3'd0, 32'h0000_0000, 20'd0);
      send_beat(CMD_WRITE, 3'd1, 32'h0000_0000, 20'd0);
      send_beat(CMD_WRITE, 3'd2, 32'h0000_0000, 20'd0);
      send_beat(CMD_WRITE, 3'd4, 32'h0000_0001, 20'd0);
      send_beat(CMD_SEARCH, 3'd0, 32'd0, 20'd1);
      send_beat(CMD_WRITE, 3'd1, 32'h8000_0000, 20'd0);
      send_beat(CMD_SEARCH, 3'd0, 32'd0, 20'd1);
      send_beat(CMD_SEARCH, 3'd0, 32'd0, 20'd8193);
      wait_all_results();

      for (int p = 0; p < 8; p++) begin
         write_region_size(phase_shift[p][SHIFT_W-1:0]);
         for (int n = 0; n < 160; n++) begin
            if (p != 3 && $urandom_range(0, 99) < 36)
               idle_gap($urandom_range(1, 12));
            else if ($urandom_range(0, 59) == 0)
               wait_all_results();
            if ($urandom_range(0, 2) == 0)
               send_beat(CMD_WRITE, INDEX_W'($urandom_range(0, 7)), pick_map_word(),
                         BYTES_W'($urandom));
            else
               send_beat(CMD_SEARCH, INDEX_W'($urandom), $urandom,
                         pick_request_bytes());
         end
         wait_all_results();
      end

      if (fail_total == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+src
src/bfrs_pkg.sv
src/bfrs_map_ram.sv
src/bfrs_word_scan.sv
src/bitmap_free_run_search.sv
dv/free_run_checker.sv
dv/tb_bitmap_free_run_search.sv
